// ===== design/oaht_pkg.sv =====
// Shared constants and types for the open-address hash table.
`timescale 1ns / 1ps
package oaht_pkg;
  localparam int TABLE_DEPTH_DEF   = 128;
  localparam int MAX_KEY_CHARS_DEF = 8;
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;
  localparam logic REG_TABLE_SIZE = 1'b0;
  localparam logic REG_PROBE_MODE = 1'b1;
  localparam logic [7:0] SIZE_RESET = 8'd101;

  // Absolute value of a wrapped 32-bit hash, saturating the most negative value.
  function automatic logic [31:0] abs_sat(input logic [31:0] h);
    logic [31:0] r;
    if (h == 32'h8000_0000) r = 32'h7FFF_FFFF;
    else if (h[31]) r = ~h + 32'd1;
    else r = h;
    return r;
  endfunction

  typedef struct packed {
    logic start;
    logic [31:0] num;
  } mod_req_t;
endpackage

// ===== design/oaht_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== design/oaht_mod.sv =====
// Restoring divider returning the remainder of a 32-bit value by a divisor.
`timescale 1ns / 1ps
module oaht_mod #(
  parameter int DW = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  oaht_pkg::mod_req_t req,
  input  logic [DW-1:0]     divisor,
  output logic              done,
  output logic [DW-1:0]     rem
);
  logic [31:0] num;
  logic [DW:0] acc;
  logic [5:0]  cnt;
  logic        busy;
  logic [DW:0] trial;
  logic [DW:0] shifted;

  always_comb begin
    shifted = {acc[DW-1:0], num[31]};
    trial   = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        num  <= req.num;
        acc  <= '0;
        cnt  <= 6'd0;
      end else if (busy) begin
        num <= {num[30:0], 1'b0};
        acc <= trial[DW] ? shifted : trial;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rem = acc[DW-1:0];
endmodule

// ===== design/open_address_hash_table.sv =====
// Top level of the open-address hash table with linear or double-hash probing.
`timescale 1ns / 1ps
// Usage: a request is accepted on a rising edge with start high and busy low.
// req_type selects clear, insert or look-up; key_chars and key_length give the
// key. Exactly one result follows per request, shown for one cycle with
// done high, carrying status, slot and probe_count. The receiver cannot stall
// the block, so the result is simply presented once and dropped.
// Configuration (table_size, probe_mode) is written through cfg_we, cfg_index
// and cfg_data while the block is idle; a write lands on the next edge.
// Operation: the key is hashed one character per cycle, after which the
// remainder unit is started. The first hash, and with double hashing the
// second, is then reduced by a shared bit-serial remainder unit. The probe walk
// reads the slot memories once per probe (read, then compare and write back),
// up to the active table size. A clear walks every slot of the occupancy
// memory, one per cycle.
// After reset the block clears every slot of the occupancy memory with busy
// high; configuration writes are taken during that pass.
module open_address_hash_table #(
  parameter int TABLE_DEPTH   = oaht_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_KEY_CHARS = oaht_pkg::MAX_KEY_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [63:0] key_chars,
  input  logic [3:0]  key_length,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [6:0]  slot,
  output logic [7:0]  probe_count
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = $clog2(MAX_KEY_CHARS + 1);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HASH   = 4'd2;
  localparam logic [3:0] S_MOD1   = 4'd3;
  localparam logic [3:0] S_MOD2   = 4'd4;
  localparam logic [3:0] S_READ   = 4'd5;
  localparam logic [3:0] S_CHECK  = 4'd6;
  localparam logic [3:0] S_CLEAR  = 4'd7;
  localparam logic [3:0] S_REPORT = 4'd8;
  localparam logic [3:0] S_WAIT1  = 4'd9;
  localparam logic [3:0] S_WAIT2  = 4'd10;

  logic [3:0]  state;
  logic [7:0]  table_size;
  logic        probe_mode;
  logic [1:0]  req;
  logic [63:0] key;
  logic [LW-1:0] len;
  logic [LW-1:0] hidx;
  logic [31:0] h31, h37;
  logic [SW-1:0] size;
  logic [AW-1:0] idx, step_m1;
  logic [SW-1:0] probes;
  logic [AW-1:0] sweep;
  logic [1:0]  res_status;
  logic [AW-1:0] res_slot;

  // Clamp of the configured size into [2, TABLE_DEPTH].
  logic [SW-1:0] size_clamped;
  always_comb begin
    if (table_size < 8'd2) size_clamped = SW'(2);
    else if (32'(table_size) > 32'(TABLE_DEPTH)) size_clamped = SW'(TABLE_DEPTH);
    else size_clamped = SW'(table_size);
  end

  // Length clamp and key normalisation at acceptance.
  logic [3:0]  len_in;
  logic [63:0] key_in;
  always_comb begin
    len_in = key_length;
    if (len_in == 4'd0) len_in = 4'd1;
    if (32'(len_in) > MAX_KEY_CHARS) len_in = 4'(MAX_KEY_CHARS);
    for (int i = 0; i < 8; i++) begin
      key_in[8*i +: 8] = (i < 32'(len_in)) ? {1'b0, key_chars[8*i +: 7]} : 8'd0;
    end
  end

  logic [6:0] cur_char;
  assign cur_char = key[8*hidx +: 7];

  // Remainder unit shared by both hash reductions.
  oaht_pkg::mod_req_t mreq;
  logic [SW-1:0] mdiv;
  logic          mdone;
  logic [SW-1:0] mrem;
  oaht_mod #(.DW(SW)) u_mod (
    .clk(clk), .rst(rst), .req(mreq), .divisor(mdiv), .done(mdone), .rem(mrem)
  );

  // Slot memories: keys with lengths, and occupancy.
  logic          kwe, uwe, uwdata;
  logic [AW-1:0] maddr;
  logic [63:0]   krd;
  logic [3:0]    lrd;
  logic          urd;
  oaht_ram #(.WIDTH(68), .DEPTH(TABLE_DEPTH)) u_keys (
    .clk(clk), .we(kwe), .addr(maddr), .wdata({4'(len), key}), .rdata({lrd, krd})
  );
  oaht_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_used (
    .clk(clk), .we(uwe), .addr(maddr), .wdata(uwdata), .rdata(urd)
  );

  logic match;
  assign match = (krd == key) && (lrd == 4'(len));

  // Next probe index, modulo the active size.
  logic [SW:0] nsum;
  logic [AW-1:0] nidx;
  always_comb begin
    nsum = {1'b0, SW'(idx)} + {1'b0, SW'(step_m1)} + (SW+1)'(1);
    if (nsum >= {1'b0, size}) nsum = nsum - {1'b0, size};
    nidx = AW'(nsum);
  end

  always_comb begin
    mreq.start = 1'b0;
    mreq.num   = oaht_pkg::abs_sat(h31);
    mdiv       = size;
    if (state == S_HASH && hidx == len) mreq.start = 1'b1;
    if (state == S_MOD2) begin
      mdiv = size - SW'(1);
      mreq.num = oaht_pkg::abs_sat(h37);
    end
    if (state == S_MOD1 && mdone && probe_mode) begin
      mreq.start = 1'b1;
      mreq.num   = oaht_pkg::abs_sat(h37);
      mdiv       = size - SW'(1);
    end
    maddr  = (state == S_INIT || state == S_CLEAR) ? sweep : idx;
    uwe    = (state == S_INIT || state == S_CLEAR) ||
             (state == S_CHECK && !urd && req == oaht_pkg::REQ_INSERT);
    uwdata = (state == S_CHECK);
    kwe    = (state == S_CHECK && !urd && req == oaht_pkg::REQ_INSERT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      sweep      <= '0;
      table_size <= oaht_pkg::SIZE_RESET;
      probe_mode <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == oaht_pkg::REG_TABLE_SIZE) table_size <= cfg_data;
        else probe_mode <= cfg_data[0];
      end
      case (state)
        S_INIT, S_CLEAR: begin
          sweep <= sweep + AW'(1);
          if (32'(sweep) == TABLE_DEPTH - 1) begin
            sweep <= '0;
            state <= (state == S_INIT) ? S_IDLE : S_REPORT;
          end
        end
        S_IDLE: begin
          if (start) begin
            req        <= req_type;
            key        <= key_in;
            len        <= LW'(len_in);
            size       <= size_clamped;
            hidx       <= '0;
            h31        <= '0;
            h37        <= '0;
            step_m1    <= '0;
            res_status <= oaht_pkg::ST_DONE;
            res_slot   <= '0;
            probes     <= '0;
            case (req_type)
              oaht_pkg::REQ_CLEAR: state <= S_CLEAR;
              oaht_pkg::REQ_INSERT, oaht_pkg::REQ_LOOKUP: state <= S_HASH;
              default: state <= S_REPORT;
            endcase
          end
        end
        S_HASH: begin
          if (hidx == len) begin
            state <= S_MOD1;
          end else begin
            h31  <= (h31 << 5) - h31 + 32'(cur_char);
            h37  <= (h37 << 5) + (h37 << 2) + h37 + 32'(cur_char);
            hidx <= hidx + LW'(1);
          end
        end
        S_MOD1: begin
          if (mdone) begin
            idx   <= AW'(mrem);
            state <= probe_mode ? S_MOD2 : S_READ;
          end
        end
        S_MOD2: begin
          if (mdone) begin
            step_m1 <= AW'(mrem);
            state   <= S_READ;
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          probes <= probes + SW'(1);
          if (!urd) begin
            if (req == oaht_pkg::REQ_INSERT) begin
              res_status <= oaht_pkg::ST_DONE;
              res_slot   <= idx;
            end else begin
              res_status <= oaht_pkg::ST_NOT_FOUND;
            end
            state <= S_REPORT;
          end else if (req == oaht_pkg::REQ_LOOKUP && match) begin
            res_status <= oaht_pkg::ST_FOUND;
            res_slot   <= idx;
            state      <= S_REPORT;
          end else if (probes + SW'(1) == size) begin
            res_status <= (req == oaht_pkg::REQ_INSERT) ? oaht_pkg::ST_FULL
                                                        : oaht_pkg::ST_NOT_FOUND;
            state <= S_REPORT;
          end else begin
            idx   <= nidx;
            state <= S_READ;
          end
        end
        S_REPORT: begin
          done        <= 1'b1;
          status      <= res_status;
          slot        <= 7'(res_slot);
          probe_count <= 8'(probes);
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
endmodule

// ===== design/oaht_checker.sv =====
// Port-level checker for the open-address hash table, bound to the top level.
`timescale 1ns / 1ps
module oaht_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] status,
  input logic [7:0] probe_count,
  input logic [6:0] slot
);
  // A request taken makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request accepted but not busy");
  // A result pulse never repeats back to back.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result held for two cycles");
  // A result follows only a busy period.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a request");
  // Not found and full results carry slot zero.
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == oaht_pkg::ST_NOT_FOUND || status == oaht_pkg::ST_FULL))
    |-> slot == 7'd0)
    else $error("slot set on a miss");
  // A miss or a full table has examined at least one slot.
  a_miss_probes: assert property (@(posedge clk) disable iff (rst)
    (done && (status == oaht_pkg::ST_NOT_FOUND || status == oaht_pkg::ST_FULL))
    |-> probe_count != 8'd0)
    else $error("miss reported with no slot examined");
endmodule

bind open_address_hash_table oaht_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .probe_count(probe_count), .slot(slot)
);
